// File: rtl/core/mva_pkg.sv
// Shared constants for the MIDI voice allocator.
// Status codes, note map size and default configuration; no dependencies.
`timescale 1ns / 1ps

package mva_pkg;

  localparam int CHANNELS_DEF   = 16;
  localparam int VOICE_SPAN_DEF = 4;

  localparam int NOTE_COUNT = 128;
  localparam int NOTE_W     = 7;

  localparam logic [7:0] STATUS_NOTE_OFF = 8'd128;
  localparam logic [7:0] STATUS_NOTE_ON  = 8'd144;

endpackage

// File: rtl/core/mva_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/midi_voice_allocator.sv
// MIDI voice allocator top level: note/channel maps and the allocation sequencer.
// Depends on mva_pkg and mva_ram.
`timescale 1ns / 1ps

// Handles one MIDI word at a time; in_stall is high while a word is being
// worked on. A note-off for a mapped note goes through S_OFF_RD and then
// S_EMIT, which loads its word into the output register; a note-on goes
// through S_MOD, where subtract steps bring start_channel below CHANNELS
// (none whenever CHANNELS > 15), then S_PROBE, which probes 1 to
// VOICE_SPAN channels, one per cycle through the channel-valid bits,
// then S_STEAL to read the victim's note when a voice is stolen, then S_WRITE
// and S_EMIT. While the previous word is held off by out_stall, the new word
// waits in S_EMIT before it is loaded. Ignored status bytes and note-offs
// for unmapped notes are dropped when accepted and give no word.
// Both maps are empty straight after reset; no clearing pass is needed.
module midi_voice_allocator
  import mva_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int VOICE_SPAN = VOICE_SPAN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  status_byte,
  input  logic [6:0]  note_number,
  input  logic [3:0]  start_channel,
  input  logic [7:0]  macro_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  voice_channel,
  output logic        is_release,
  output logic [7:0]  note_code,
  output logic [7:0]  row_macro,
  output logic        record_row
);

  localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW   = ((CW > 4) ? CW : 4) + 1;
  localparam int PCW  = (VOICE_SPAN > 1) ? $clog2(VOICE_SPAN) : 1;
  localparam int CNTW = $clog2(CHANNELS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_OFF_RD = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_PROBE  = 3'd3;
  localparam logic [2:0] S_STEAL  = 3'd4;
  localparam logic [2:0] S_WRITE  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]            state;
  logic [NOTE_COUNT-1:0] note_valid;
  logic [CHANNELS-1:0]   chan_valid;
  logic [CNTW-1:0]       active_cnt;
  logic [SW-1:0]         chan;
  logic [PCW-1:0]        probe_cnt;
  logic [NOTE_W-1:0]     note;
  logic [7:0]            macro;
  logic                  release_row;
  logic                  record;

  logic [CW-1:0]     chan_idx;
  logic [SW-1:0]     chan_inc;
  logic [CW-1:0]     note_map_rdata;
  logic [NOTE_W-1:0] chan_map_rdata;
  logic              map_we;
  logic              accept;

  assign chan_idx = chan[CW-1:0];
  assign chan_inc = (chan + SW'(1) == SW'(CHANNELS)) ? '0 : chan + SW'(1);
  assign map_we   = (state == S_WRITE);
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  mva_ram #(
    .WIDTH (CW),
    .DEPTH (NOTE_COUNT)
  ) u_note_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (note),
    .wdata (chan_idx),
    .raddr (note_number),
    .rdata (note_map_rdata)
  );

  mva_ram #(
    .WIDTH (NOTE_W),
    .DEPTH (CHANNELS)
  ) u_chan_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (chan_idx),
    .wdata (note),
    .raddr (chan_idx),
    .rdata (chan_map_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      note_valid <= '0;
      chan_valid <= '0;
      active_cnt <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            note      <= note_number;
            macro     <= macro_value;
            chan      <= SW'(start_channel);
            probe_cnt <= '0;
            if (status_byte == STATUS_NOTE_OFF && note_valid[note_number]) begin
              state <= S_OFF_RD;
            end else if (status_byte == STATUS_NOTE_ON) begin
              state <= S_MOD;
            end
          end
        end
        S_OFF_RD: begin
          chan                       <= SW'(note_map_rdata);
          chan_valid[note_map_rdata] <= 1'b0;
          note_valid[note]           <= 1'b0;
          active_cnt                 <= active_cnt - CNTW'(1);
          record                     <= (active_cnt == CNTW'(1));
          release_row                <= 1'b1;
          state                      <= S_EMIT;
        end
        S_MOD: begin
          if (chan >= SW'(CHANNELS)) begin
            chan <= chan - SW'(CHANNELS);
          end else begin
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (!chan_valid[chan_idx] || probe_cnt == PCW'(VOICE_SPAN - 1)) begin
            state <= chan_valid[chan_idx] ? S_STEAL : S_WRITE;
          end else begin
            chan      <= chan_inc;
            probe_cnt <= probe_cnt + PCW'(1);
          end
        end
        S_STEAL: begin
          note_valid[chan_map_rdata] <= 1'b0;
          state                      <= S_WRITE;
        end
        S_WRITE: begin
          chan_valid[chan_idx] <= 1'b1;
          if (!chan_valid[chan_idx]) begin
            active_cnt <= active_cnt + CNTW'(1);
          end
          note_valid[note] <= 1'b1;
          record           <= 1'b1;
          release_row      <= 1'b0;
          state            <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            voice_channel <= 4'(chan);
            is_release    <= release_row;
            note_code     <= release_row ? 8'd0 : 8'(note) + 8'd1;
            row_macro     <= release_row ? 8'd0 : macro;
            record_row    <= record;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    active_cnt == CNTW'($countones(chan_valid)))
    else $error("active voice count out of step with channel valid bits");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_EMIT)
    else $error("output word raised outside the emit step");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |=> note_valid[$past(note)] && chan_valid[$past(chan_idx)])
    else $error("note-on left its note or channel unmapped");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> chan < SW'(CHANNELS))
    else $error("probe channel out of range");

endmodule

// File: dv/tb_midi_voice_allocator.sv
// Self-checking testbench for midi_voice_allocator: note-on/note-off words,
// voice stealing and random traffic checked against an in-bench voice map.
// Depends on mva_pkg and the midi_voice_allocator RTL.
`timescale 1ns / 1ps

module tb_midi_voice_allocator;
  import mva_pkg::*;

  localparam int CH        = CHANNELS_DEF;
  localparam int SPAN      = VOICE_SPAN_DEF;
  localparam int RAND_ITEMS = 1900;
  localparam int DIR_N     = 24;
  localparam int MAX_PRINT = 100;

  typedef struct packed {
    logic [3:0] chan;
    logic       rel;
    logic [7:0] code;
    logic [7:0] mac;
    logic       rec;
  } voice_row_t;

  typedef struct {
    logic [7:0] st;
    logic [6:0] nt;
    logic [3:0] sc;
    logic [7:0] mv;
    bit         typed;
    bit         has_row;
    voice_row_t row;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] status_byte = '0;
  logic [6:0] note_number = '0;
  logic [3:0] start_channel = '0;
  logic [7:0] macro_value = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] voice_channel;
  logic       is_release;
  logic [7:0] note_code;
  logic [7:0] row_macro;
  logic       record_row;

  midi_voice_allocator #(
    .CHANNELS   (CH),
    .VOICE_SPAN (SPAN)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .status_byte   (status_byte),
    .note_number   (note_number),
    .start_channel (start_channel),
    .macro_value   (macro_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .voice_channel (voice_channel),
    .is_release    (is_release),
    .note_code     (note_code),
    .row_macro     (row_macro),
    .record_row    (record_row)
  );

  bit         note_ok   [NOTE_COUNT];
  bit [3:0]   note_chan [NOTE_COUNT];
  bit         chan_ok   [CH];
  bit [6:0]   chan_note [CH];

  voice_row_t pending_rows [$];
  stim_row_t  dir_rows [DIR_N];
  int         err_count   = 0;
  int         words_sent  = 0;
  int         tx_idle_pct = 32;
  int         rx_idle_pct = 53;
  bit         hold_off    = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bit allot_voice(input logic [7:0] st, input logic [6:0] nt,
                                     input logic [3:0] sc, input logic [7:0] mv,
                                     output voice_row_t row);
    int chan;
    bit any;
    row = '0;
    any = 1'b0;
    if (st == STATUS_NOTE_OFF) begin
      if (!note_ok[nt]) return 1'b0;
      chan = int'(note_chan[nt]);
      chan_ok[chan]   = 1'b0;
      chan_note[chan] = '0;
      note_ok[nt]     = 1'b0;
      note_chan[nt]   = '0;
      for (int i = 0; i < CH; i++) any |= chan_ok[i];
      row.chan = chan[3:0];
      row.rel  = 1'b1;
      row.rec  = !any;
      return 1'b1;
    end
    if (st == STATUS_NOTE_ON) begin
      chan = int'(sc) % CH;
      for (int i = 1; i < SPAN; i++) begin
        if (!chan_ok[chan]) break;
        chan = (chan + 1) % CH;
      end
      if (chan_ok[chan]) begin
        note_ok[chan_note[chan]]   = 1'b0;
        note_chan[chan_note[chan]] = '0;
      end
      chan_ok[chan]   = 1'b1;
      chan_note[chan] = nt;
      note_ok[nt]     = 1'b1;
      note_chan[nt]   = chan[3:0];
      row.chan = chan[3:0];
      row.code = {1'b0, nt} + 8'd1;
      row.mac  = mv;
      row.rec  = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic flag_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINT) $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic send_word(input logic [7:0] st, input logic [6:0] nt,
                           input logic [3:0] sc, input logic [7:0] mv);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    status_byte   <= st;
    note_number   <= nt;
    start_channel <= sc;
    macro_value   <= mv;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Check each word leaving the block against the oldest expected row.
  always @(posedge clk) begin
    voice_row_t want;
    voice_row_t got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{voice_channel, is_release, note_code, row_macro, record_row};
        if (pending_rows.size() == 0) begin
          flag_mismatch($sformatf("unexpected word %h", got));
        end else begin
          want = pending_rows.pop_front();
          if (got.chan !== want.chan || got.rel !== want.rel || got.code !== want.code ||
              got.mac !== want.mac || got.rec !== want.rec)
            flag_mismatch($sformatf(
              "chan %0d/%0d rel %0d/%0d code %0d/%0d mac %0d/%0d rec %0d/%0d",
              got.chan, want.chan, got.rel, want.rel, got.code,
              want.code, got.mac, want.mac, got.rec, want.rec));
        end
      end
      out_stall <= hold_off || ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Hold the output off long enough for the block to back up onto its input.
  initial begin
    wait (words_sent >= 150);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    voice_row_t row;
    stim_row_t  d;
    int         handled;
    int         sel;
    int         held [$];
    logic [7:0] st;
    logic [6:0] nt;
    logic [3:0] sc;
    logic [7:0] mv;

    dir_rows = '{
      '{STATUS_NOTE_ON,  7'd0,   4'd0,  8'd0,   1, 1, '{4'd0,  1'b0, 8'd1,   8'd0,   1'b1}},
      '{STATUS_NOTE_ON,  7'd127, 4'd15, 8'd255, 1, 1, '{4'd15, 1'b0, 8'd128, 8'd255, 1'b1}},
      '{STATUS_NOTE_OFF, 7'd0,   4'd0,  8'd0,   1, 1, '{4'd0,  1'b1, 8'd0,   8'd0,   1'b0}},
      '{STATUS_NOTE_OFF, 7'd127, 4'd0,  8'd0,   1, 1, '{4'd15, 1'b1, 8'd0,   8'd0,   1'b1}},
      '{STATUS_NOTE_OFF, 7'd127, 4'd0,  8'd0,   1, 0, '0},
      '{8'd0,            7'd85,  4'd5,  8'd170, 1, 0, '0},
      '{8'd255,          7'd42,  4'd10, 8'd85,  1, 0, '0},
      '{8'd129,          7'd0,   4'd0,  8'd0,   1, 0, '0},
      '{8'd143,          7'd0,   4'd0,  8'd0,   1, 0, '0},
      '{8'd145,          7'd1,   4'd3,  8'd7,   1, 0, '0},
      '{STATUS_NOTE_ON,  7'd10,  4'd2,  8'd1,   0, 0, '0},
      '{STATUS_NOTE_ON,  7'd11,  4'd2,  8'd2,   0, 0, '0},
      '{STATUS_NOTE_ON,  7'd12,  4'd2,  8'd3,   0, 0, '0},
      '{STATUS_NOTE_ON,  7'd13,  4'd2,  8'd4,   0, 0, '0},
      '{STATUS_NOTE_ON,  7'd14,  4'd2,  8'd5,   0, 0, '0},
      '{STATUS_NOTE_OFF, 7'd13,  4'd0,  8'd0,   0, 0, '0},
      '{STATUS_NOTE_ON,  7'd10,  4'd9,  8'd6,   0, 0, '0},
      '{STATUS_NOTE_ON,  7'd20,  4'd14, 8'd7,   0, 0, '0},
      '{STATUS_NOTE_ON,  7'd21,  4'd14, 8'd8,   0, 0, '0},
      '{STATUS_NOTE_ON,  7'd22,  4'd14, 8'd9,   0, 0, '0},
      '{STATUS_NOTE_OFF, 7'd10,  4'd0,  8'd0,   0, 0, '0},
      '{STATUS_NOTE_OFF, 7'd11,  4'd0,  8'd0,   0, 0, '0},
      '{STATUS_NOTE_ON,  7'd100, 4'd7,  8'd128, 0, 0, '0},
      '{STATUS_NOTE_OFF, 7'd14,  4'd0,  8'd0,   0, 0, '0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      d = dir_rows[i];
      send_word(d.st, d.nt, d.sc, d.mv);
      if (allot_voice(d.st, d.nt, d.sc, d.mv, row) && !d.typed) pending_rows.push_back(row);
      if (d.typed && d.has_row) pending_rows.push_back(d.row);
    end

    handled = 0;
    while (handled < RAND_ITEMS) begin
      if (handled < RAND_ITEMS / 3) begin
        tx_idle_pct = 32;
        rx_idle_pct = 53;
      end else if (handled < 2 * RAND_ITEMS / 3) begin
        tx_idle_pct = 53;
        rx_idle_pct = 32;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      sel = int'($urandom_range(99));
      nt  = $urandom_range(1) ? 7'($urandom_range(127)) : 7'(60 + $urandom_range(11));
      sc  = 4'($urandom_range(15));
      mv  = 8'($urandom_range(255));
      if (sel < 48) begin
        st = STATUS_NOTE_ON;
      end else if (sel < 88) begin
        st = STATUS_NOTE_OFF;
        held.delete();
        for (int n = 0; n < NOTE_COUNT; n++) if (note_ok[n]) held.push_back(n);
        if (held.size() != 0) nt = 7'(held[$urandom_range(held.size() - 1)]);
      end else if (sel < 94) begin
        st = STATUS_NOTE_OFF;
      end else begin
        st = 8'($urandom_range(255));
      end
      send_word(st, nt, sc, mv);
      if (allot_voice(st, nt, sc, mv, row)) pending_rows.push_back(row);
      if (st == STATUS_NOTE_ON || st == STATUS_NOTE_OFF) handled++;
    end
    in_valid <= 1'b0;

    wait (pending_rows.size() == 0);
    repeat (30) @(posedge clk);
    if (err_count == 0 && pending_rows.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
